// File: hw/rtl/atmp_pkg.sv
package atmp_pkg;

  // Result codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_REPLY   = 3'd1;
  localparam logic [2:0] ST_REPLY_ERR  = 3'd2;
  localparam logic [2:0] ST_NO_SYNC    = 3'd3;
  localparam logic [2:0] ST_WRONG_TYPE = 3'd4;
  localparam logic [2:0] ST_MISSING    = 3'd5;

  localparam int STATUS_CHARS_DEF = 8;
  localparam int TEXT_BYTES       = 8;

  // Characters
  localparam logic [7:0] CH_LT    = 8'h3C; // '<'
  localparam logic [7:0] CH_O     = 8'h4F; // 'O'
  localparam logic [7:0] CH_K     = 8'h4B; // 'K'
  localparam logic [7:0] CH_HASH  = 8'h23; // '#'
  localparam logic [7:0] CH_COMMA = 8'h2C; // ','
  localparam logic [7:0] CH_SEMI  = 8'h3B; // ';'
  localparam logic [7:0] CH_STAR  = 8'h2A; // '*'
  localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D; // '-'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Type token after the '#'
  localparam logic [3:0] TYPE_LEN = 4'd9;
  localparam logic [3:0] TYPE_BAD = 4'd15;

  localparam logic [35:0] MAG_CAP = 36'h0_8000_0000;

  function automatic logic [7:0] type_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h54; // T
      4'd1:    c = 8'h49; // I
      4'd2:    c = 8'h4D; // M
      4'd3:    c = 8'h45; // E
      4'd4:    c = 8'h53; // S
      4'd5:    c = 8'h59; // Y
      4'd6:    c = 8'h4E; // N
      4'd7:    c = 8'h43; // C
      4'd8:    c = 8'h41; // A
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic fin;   // digits ended
    logic dig;   // at least one digit
    logic neg;   // minus sign seen
    logic start; // past leading whitespace
  } nflags_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         parse_status;
    logic signed [31:0] week_number;
    logic signed [31:0] offset_millis;
    logic [63:0]        status_text;
    logic [3:0]         status_length;
  } out_item_t;

endpackage

// File: hw/rtl/atmp_num.sv
// One character step of the decimal reader, plus the signed saturated value.
module atmp_num (
  input  logic [31:0]      acc_i,
  input  atmp_pkg::nflags_t flags_i,
  input  logic [7:0]       byte_i,
  output logic [31:0]      acc_o,
  output atmp_pkg::nflags_t flags_o,
  output logic [31:0]      value_o
);

  logic        is_space;
  logic        is_digit;
  logic [35:0] mag;

  assign is_space = (byte_i == atmp_pkg::CH_SPACE) ||
                    ((byte_i >= atmp_pkg::CH_TAB) && (byte_i <= atmp_pkg::CH_CR));
  assign is_digit = (byte_i >= atmp_pkg::CH_ZERO) && (byte_i <= atmp_pkg::CH_NINE);

  // acc*10 + digit as two shifts and two adds
  assign mag = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0}
             + {32'd0, 4'(byte_i - atmp_pkg::CH_ZERO)};

  always_comb begin
    acc_o   = acc_i;
    flags_o = flags_i;
    if (!flags_i.fin) begin
      if (!flags_i.start && is_space) begin
        flags_o = flags_i;
      end else if (!flags_i.start &&
                   (byte_i == atmp_pkg::CH_PLUS || byte_i == atmp_pkg::CH_MINUS)) begin
        flags_o.start = 1'b1;
        flags_o.neg   = (byte_i == atmp_pkg::CH_MINUS);
      end else begin
        flags_o.start = 1'b1;
        if (is_digit) begin
          acc_o       = (mag > atmp_pkg::MAG_CAP) ? atmp_pkg::MAG_CAP[31:0] : mag[31:0];
          flags_o.dig = 1'b1;
        end else begin
          flags_o.fin = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (flags_i.neg) begin
      value_o = 32'd0 - acc_i;
    end else begin
      value_o = acc_i[31] ? 32'h7FFF_FFFF : acc_i;
    end
  end

endmodule

// File: hw/rtl/ascii_time_message_parser.sv
// ascii_time_message_parser: streams a time-sync reply one byte per transfer
// and returns one result per message. A message ends on a byte with
// end_of_message set (that byte is parsed first) or on a zero byte (not
// parsed). The reply must open with "<OK", the token after '#' must be
// "TIMESYNCA", the header runs to ';', then come week and millisecond
// offset as decimal integers (saturated to 32 bits) and a status text up to
// '*', of which the first STATUS_CHARS characters are kept. The first
// failure wins; on failure all fields read zero. The parser state updates
// from the incoming byte in the cycle it is taken, so a byte may be
// transferred on every clock while in_stall is low. Results go through an
// output register backed by a one-entry skid register; in_stall rises only
// while that skid register is occupied, i.e. two results are waiting downstream.
module ascii_time_message_parser #(
  parameter int STATUS_CHARS = atmp_pkg::STATUS_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  atmp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output atmp_pkg::out_item_t out_data
);

  // Parser phases
  localparam logic [3:0] PH_OPEN  = 4'd0;
  localparam logic [3:0] PH_O     = 4'd1;
  localparam logic [3:0] PH_K     = 4'd2;
  localparam logic [3:0] PH_SEEK  = 4'd3;
  localparam logic [3:0] PH_TYPE  = 4'd4;
  localparam logic [3:0] PH_HLEAD = 4'd5;
  localparam logic [3:0] PH_HDR   = 4'd6;
  localparam logic [3:0] PH_WLEAD = 4'd7;
  localparam logic [3:0] PH_WEEK  = 4'd8;
  localparam logic [3:0] PH_OLEAD = 4'd9;
  localparam logic [3:0] PH_OFF   = 4'd10;
  localparam logic [3:0] PH_SLEAD = 4'd11;
  localparam logic [3:0] PH_STAT  = 4'd12;
  localparam logic [3:0] PH_TAIL  = 4'd13;
  localparam logic [3:0] PH_FAIL  = 4'd14;

  localparam logic [3:0] TEXT_LIMIT = 4'(STATUS_CHARS);

  // Parser state
  logic [3:0]        phase_r, phase_nxt;
  logic [3:0]        match_r, match_nxt;
  logic [2:0]        error_r, error_nxt;
  logic [31:0]       week_r, week_nxt;
  logic [31:0]       off_r, off_nxt;
  atmp_pkg::nflags_t flags_r, flags_nxt;
  logic [63:0]       text_r, text_nxt;
  logic [3:0]        count_r, count_nxt;

  // State after the current byte, before any end-of-message clear
  logic [3:0]        phase_t, match_t;
  logic [2:0]        error_t;
  logic [31:0]       week_t, off_t;
  atmp_pkg::nflags_t flags_t;
  logic [63:0]       text_t;
  logic [3:0]        count_t;

  // Shared number unit
  logic [31:0]       num_acc_i, num_acc_o, num_value;
  atmp_pkg::nflags_t num_flags_i, num_flags_o;

  // Output register and skid
  logic                out_valid_r, skid_valid_r;
  atmp_pkg::out_item_t out_r, skid_r;

  logic                in_xfer, msg_end, res_vld, out_take;
  logic [7:0]          b;
  logic [2:0]          st;
  atmp_pkg::out_item_t res;

  assign b        = in_data.byte_in;
  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !in_stall;
  assign msg_end  = (b == 8'd0) || in_data.end_of_message;
  assign res_vld  = in_xfer && msg_end;
  assign out_take = out_valid_r && !out_stall;

  // Lead phases start a fresh number; digit phases continue the running one
  always_comb begin
    case (phase_r)
      PH_WEEK: begin
        num_acc_i   = week_r;
        num_flags_i = flags_r;
      end
      PH_OFF: begin
        num_acc_i   = off_r;
        num_flags_i = flags_r;
      end
      default: begin
        num_acc_i   = 32'd0;
        num_flags_i = '0;
      end
    endcase
  end

  atmp_num u_num (
    .acc_i   (num_acc_i),
    .flags_i (num_flags_i),
    .byte_i  (b),
    .acc_o   (num_acc_o),
    .flags_o (num_flags_o),
    .value_o (num_value)
  );

  // One byte of the parser
  always_comb begin
    phase_t = phase_r;
    match_t = match_r;
    error_t = error_r;
    week_t  = week_r;
    off_t   = off_r;
    flags_t = flags_r;
    text_t  = text_r;
    count_t = count_r;
    if (b != 8'd0) begin
      case (phase_r)
        PH_OPEN: begin
          if (b == atmp_pkg::CH_LT) begin
            phase_t = PH_O;
          end else begin
            phase_t = PH_FAIL;
            error_t = atmp_pkg::ST_NO_REPLY;
          end
        end
        PH_O: begin
          if (b == atmp_pkg::CH_O) begin
            phase_t = PH_K;
          end else begin
            phase_t = PH_FAIL;
            error_t = atmp_pkg::ST_REPLY_ERR;
          end
        end
        PH_K: begin
          if (b == atmp_pkg::CH_K) begin
            phase_t = PH_SEEK;
          end else begin
            phase_t = PH_FAIL;
            error_t = atmp_pkg::ST_REPLY_ERR;
          end
        end
        PH_SEEK: begin
          if (b == atmp_pkg::CH_HASH) begin
            phase_t = PH_TYPE;
            match_t = 4'd0;
          end
        end
        PH_TYPE: begin
          if (b == atmp_pkg::CH_COMMA) begin
            if (match_r == atmp_pkg::TYPE_LEN) begin
              phase_t = PH_HLEAD;
            end else begin
              phase_t = PH_FAIL;
              error_t = atmp_pkg::ST_WRONG_TYPE;
            end
          end else if (match_r < atmp_pkg::TYPE_LEN && b == atmp_pkg::type_char(match_r)) begin
            match_t = match_r + 4'd1;
          end else begin
            match_t = atmp_pkg::TYPE_BAD;
          end
        end
        PH_HLEAD: begin
          if (b != atmp_pkg::CH_SEMI) begin
            phase_t = PH_HDR;
          end
        end
        PH_HDR: begin
          if (b == atmp_pkg::CH_SEMI) begin
            phase_t = PH_WLEAD;
          end
        end
        PH_WLEAD, PH_WEEK: begin
          if (b != atmp_pkg::CH_COMMA) begin
            phase_t = PH_WEEK;
            week_t  = num_acc_o;
            flags_t = num_flags_o;
          end else if (phase_r == PH_WEEK) begin
            if (!flags_r.dig) begin
              phase_t = PH_FAIL;
              error_t = atmp_pkg::ST_MISSING;
            end else begin
              week_t  = num_value;
              phase_t = PH_OLEAD;
            end
          end
        end
        PH_OLEAD, PH_OFF: begin
          if (b != atmp_pkg::CH_COMMA) begin
            phase_t = PH_OFF;
            off_t   = num_acc_o;
            flags_t = num_flags_o;
          end else if (phase_r == PH_OFF) begin
            if (!flags_r.dig) begin
              phase_t = PH_FAIL;
              error_t = atmp_pkg::ST_MISSING;
            end else begin
              off_t   = num_value;
              phase_t = PH_SLEAD;
            end
          end
        end
        PH_SLEAD, PH_STAT: begin
          if (b == atmp_pkg::CH_STAR) begin
            if (phase_r == PH_STAT) begin
              phase_t = PH_TAIL;
            end
          end else begin
            phase_t = PH_STAT;
            if (count_r < TEXT_LIMIT) begin
              for (int i = 0; i < atmp_pkg::TEXT_BYTES; i++) begin
                if (count_r[2:0] == 3'(i)) begin
                  text_t[8*i +: 8] = b;
                end
              end
              count_t = count_r + 4'd1;
            end
          end
        end
        default: begin
          phase_t = phase_r;
        end
      endcase
    end
  end

  // Status on message end, taken from the state after this byte
  always_comb begin
    case (phase_t)
      PH_FAIL:       st = error_t;
      PH_OPEN:       st = atmp_pkg::ST_NO_REPLY;
      PH_O, PH_K:    st = atmp_pkg::ST_REPLY_ERR;
      PH_SEEK:       st = atmp_pkg::ST_NO_SYNC;
      PH_TYPE:       st = (match_t == atmp_pkg::TYPE_LEN) ? atmp_pkg::ST_MISSING
                                                         : atmp_pkg::ST_WRONG_TYPE;
      PH_STAT, PH_TAIL: st = atmp_pkg::ST_OK;
      default:       st = atmp_pkg::ST_MISSING;
    endcase
  end

  always_comb begin
    res.parse_status = st;
    if (st == atmp_pkg::ST_OK) begin
      res.week_number   = week_t;
      res.offset_millis = off_t;
      res.status_text   = text_t;
      res.status_length = count_t;
    end else begin
      res.week_number   = '0;
      res.offset_millis = '0;
      res.status_text   = '0;
      res.status_length = '0;
    end
  end

  // Next state: hold when idle, clear on message end
  always_comb begin
    phase_nxt = phase_r;
    match_nxt = match_r;
    error_nxt = error_r;
    week_nxt  = week_r;
    off_nxt   = off_r;
    flags_nxt = flags_r;
    text_nxt  = text_r;
    count_nxt = count_r;
    if (in_xfer) begin
      if (msg_end) begin
        phase_nxt = PH_OPEN;
        match_nxt = 4'd0;
        error_nxt = atmp_pkg::ST_OK;
        week_nxt  = 32'd0;
        off_nxt   = 32'd0;
        flags_nxt = '0;
        text_nxt  = 64'd0;
        count_nxt = 4'd0;
      end else begin
        phase_nxt = phase_t;
        match_nxt = match_t;
        error_nxt = error_t;
        week_nxt  = week_t;
        off_nxt   = off_t;
        flags_nxt = flags_t;
        text_nxt  = text_t;
        count_nxt = count_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPEN;
      match_r <= 4'd0;
      error_r <= atmp_pkg::ST_OK;
      week_r  <= 32'd0;
      off_r   <= 32'd0;
      flags_r <= '0;
      text_r  <= 64'd0;
      count_r <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      match_r <= match_nxt;
      error_r <= error_nxt;
      week_r  <= week_nxt;
      off_r   <= off_nxt;
      flags_r <= flags_nxt;
      text_r  <= text_nxt;
      count_r <= count_nxt;
    end
  end

  // Output register with skid: a second result parks in skid_r while
  // the first is stalled, and the input side stalls until it drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_vld) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (res_vld) begin
      if (out_valid_r && !out_take) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Skid only ever fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full with output register empty");

  // A message end always leaves a result waiting
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> out_valid_r)
    else $error("message end produced no result");

  // Failed parses carry zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.parse_status != atmp_pkg::ST_OK) |->
      (out_r.week_number == 32'sd0 && out_r.offset_millis == 32'sd0 &&
       out_r.status_text == 64'd0 && out_r.status_length == 4'd0))
    else $error("failed parse with nonzero fields");

  // Text count never passes the kept length
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= TEXT_LIMIT)
    else $error("status text count beyond limit");

endmodule

// File: tb/atmp_reply_checker.sv
`timescale 1ns / 1ps

module atmp_reply_checker #(
  parameter int STATUS_CHARS = atmp_pkg::STATUS_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  atmp_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  atmp_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  awaited,
  output int                  clean_replies
);

  localparam logic [3:0] PH_OPEN  = 4'd0;
  localparam logic [3:0] PH_O     = 4'd1;
  localparam logic [3:0] PH_K     = 4'd2;
  localparam logic [3:0] PH_SEEK  = 4'd3;
  localparam logic [3:0] PH_TYPE  = 4'd4;
  localparam logic [3:0] PH_HLEAD = 4'd5;
  localparam logic [3:0] PH_HDR   = 4'd6;
  localparam logic [3:0] PH_WLEAD = 4'd7;
  localparam logic [3:0] PH_WEEK  = 4'd8;
  localparam logic [3:0] PH_OLEAD = 4'd9;
  localparam logic [3:0] PH_OFF   = 4'd10;
  localparam logic [3:0] PH_SLEAD = 4'd11;
  localparam logic [3:0] PH_STAT  = 4'd12;
  localparam logic [3:0] PH_TAIL  = 4'd13;
  localparam logic [3:0] PH_FAIL  = 4'd14;

  // first character in the top byte
  localparam logic [71:0] SYNC_WORD = "TIMESYNCA";

  logic [3:0]          phase;
  logic [3:0]          tok_idx;
  logic [2:0]          err_code;
  logic [31:0]         week_mag;
  logic [31:0]         off_mag;
  atmp_pkg::nflags_t   num_flags;
  logic [63:0]         txt;
  logic [3:0]          txt_n;
  atmp_pkg::out_item_t replies_due[$];
  atmp_pkg::out_item_t want;

  task automatic restart_parse();
    phase     = PH_OPEN;
    tok_idx   = '0;
    err_code  = '0;
    week_mag  = '0;
    off_mag   = '0;
    num_flags = '0;
    txt       = '0;
    txt_n     = '0;
  endtask

  task automatic trip(input logic [2:0] code);
    err_code = code;
    phase    = PH_FAIL;
  endtask

  function automatic logic is_blank(input logic [7:0] b);
    return b == atmp_pkg::CH_SPACE || (b >= atmp_pkg::CH_TAB && b <= atmp_pkg::CH_CR);
  endfunction

  // strtol-like digit accumulation, magnitude capped at 2^31
  task automatic num_char(inout logic [31:0] acc, input logic [7:0] b);
    logic [35:0] m;
    logic        take;
    take = !num_flags.fin;
    if (take && !num_flags.start) begin
      if (is_blank(b)) begin
        take = 1'b0;
      end else begin
        num_flags.start = 1'b1;
        if (b == atmp_pkg::CH_PLUS || b == atmp_pkg::CH_MINUS) begin
          num_flags.neg = (b == atmp_pkg::CH_MINUS);
          take = 1'b0;
        end
      end
    end
    if (take) begin
      if (b >= atmp_pkg::CH_ZERO && b <= atmp_pkg::CH_NINE) begin
        m = {4'd0, acc} * 36'd10 + {28'd0, b - atmp_pkg::CH_ZERO};
        if (m > atmp_pkg::MAG_CAP) m = atmp_pkg::MAG_CAP;
        acc = m[31:0];
        num_flags.dig = 1'b1;
      end else begin
        num_flags.fin = 1'b1;
      end
    end
  endtask

  function automatic logic [31:0] with_sign(input logic [31:0] mag, input logic neg);
    if (neg) return 32'd0 - mag;
    return (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
  endfunction

  task automatic parse_char(input logic [7:0] b);
    case (phase)
      PH_OPEN: begin
        if (b == atmp_pkg::CH_LT) phase = PH_O;
        else trip(atmp_pkg::ST_NO_REPLY);
      end
      PH_O: begin
        if (b == atmp_pkg::CH_O) phase = PH_K;
        else trip(atmp_pkg::ST_REPLY_ERR);
      end
      PH_K: begin
        if (b == atmp_pkg::CH_K) phase = PH_SEEK;
        else trip(atmp_pkg::ST_REPLY_ERR);
      end
      PH_SEEK: begin
        if (b == atmp_pkg::CH_HASH) begin
          phase   = PH_TYPE;
          tok_idx = '0;
        end
      end
      PH_TYPE: begin
        if (b == atmp_pkg::CH_COMMA) begin
          if (tok_idx == atmp_pkg::TYPE_LEN) phase = PH_HLEAD;
          else trip(atmp_pkg::ST_WRONG_TYPE);
        end else if (tok_idx < atmp_pkg::TYPE_LEN &&
                     b == SYNC_WORD[71 - 8 * tok_idx -: 8]) begin
          tok_idx++;
        end else begin
          tok_idx = atmp_pkg::TYPE_BAD;
        end
      end
      PH_HLEAD: begin
        if (b != atmp_pkg::CH_SEMI) phase = PH_HDR;
      end
      PH_HDR: begin
        if (b == atmp_pkg::CH_SEMI) phase = PH_WLEAD;
      end
      PH_WLEAD: begin
        if (b != atmp_pkg::CH_COMMA) begin
          phase     = PH_WEEK;
          num_flags = '0;
          week_mag  = '0;
          num_char(week_mag, b);
        end
      end
      PH_WEEK: begin
        if (b != atmp_pkg::CH_COMMA) begin
          num_char(week_mag, b);
        end else if (!num_flags.dig) begin
          trip(atmp_pkg::ST_MISSING);
        end else begin
          week_mag = with_sign(week_mag, num_flags.neg);
          phase    = PH_OLEAD;
        end
      end
      PH_OLEAD: begin
        if (b != atmp_pkg::CH_COMMA) begin
          phase     = PH_OFF;
          num_flags = '0;
          off_mag   = '0;
          num_char(off_mag, b);
        end
      end
      PH_OFF: begin
        if (b != atmp_pkg::CH_COMMA) begin
          num_char(off_mag, b);
        end else if (!num_flags.dig) begin
          trip(atmp_pkg::ST_MISSING);
        end else begin
          off_mag = with_sign(off_mag, num_flags.neg);
          phase   = PH_SLEAD;
        end
      end
      PH_SLEAD, PH_STAT: begin
        if (b == atmp_pkg::CH_STAR) begin
          if (phase == PH_STAT) phase = PH_TAIL;
        end else begin
          phase = PH_STAT;
          if (txt_n < STATUS_CHARS) begin
            txt[8 * txt_n +: 8] = b;
            txt_n++;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [2:0] closing_code();
    case (phase)
      PH_FAIL:        return err_code;
      PH_OPEN:        return atmp_pkg::ST_NO_REPLY;
      PH_O, PH_K:     return atmp_pkg::ST_REPLY_ERR;
      PH_SEEK:        return atmp_pkg::ST_NO_SYNC;
      PH_TYPE:        return (tok_idx == atmp_pkg::TYPE_LEN) ? atmp_pkg::ST_MISSING
                                                             : atmp_pkg::ST_WRONG_TYPE;
      PH_STAT, PH_TAIL: return atmp_pkg::ST_OK;
      default:        return atmp_pkg::ST_MISSING;
    endcase
  endfunction

  // a zero byte ends the message without being parsed
  task automatic take_transfer(input atmp_pkg::in_item_t it);
    atmp_pkg::out_item_t res;
    if (it.byte_in != 8'h00) parse_char(it.byte_in);
    if (it.byte_in == 8'h00 || it.end_of_message) begin
      res = '0;
      res.parse_status = closing_code();
      if (res.parse_status == atmp_pkg::ST_OK) begin
        res.week_number   = week_mag;
        res.offset_millis = off_mag;
        res.status_text   = txt;
        res.status_length = txt_n;
        clean_replies++;
      end
      replies_due.push_back(res);
      restart_parse();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_parse();
      replies_due.delete();
      fail_count    = 0;
      clean_replies = 0;
      awaited      <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          check_field("parse_status", 64'(want.parse_status),
                      64'(out_data.parse_status));
          check_field("week_number", 64'(want.week_number),
                      64'(out_data.week_number));
          check_field("offset_millis", 64'(want.offset_millis),
                      64'(out_data.offset_millis));
          check_field("status_text", want.status_text, out_data.status_text);
          check_field("status_length", 64'(want.status_length),
                      64'(out_data.status_length));
        end
      end
      if (in_valid && !in_stall) take_transfer(in_data);
      awaited <= replies_due.size();
    end
  end

endmodule

// File: tb/tb_ascii_time_message_parser.sv
`timescale 1ns / 1ps

module tb_ascii_time_message_parser;

  // cycles with no transfer on either side before giving up
  localparam int QUIET_LIMIT  = 2000;
  // settle time after the last result, well beyond the output pipeline
  localparam int DRAIN_CYCLES = 20;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  atmp_pkg::in_item_t  in_data   = '0;
  logic                out_stall = 1'b0;
  logic                gaps_on   = 1'b1;
  logic                in_stall;
  logic                out_valid;
  atmp_pkg::out_item_t out_data;

  int fail_count;
  int awaited;
  int clean_replies;
  int bytes_sent = 0;
  int msg_count  = 0;
  int quiet      = 0;

  // message being assembled for sending
  logic [7:0] msg[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ascii_time_message_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  atmp_reply_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .awaited       (awaited),
    .clean_replies (clean_replies)
  );

  // Receiver: stalls about a quarter of the time unless gaps are switched off.
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 25);
  end

  // Watchdog: counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("ascii_time_message_parser test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One byte transfer, with optional idle cycles before it. The payload is held
  // until the stall drops; in_stall is read just after the edge, so it is the
  // value the edge saw.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (gaps_on && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends msg; the end is flagged on the last byte, or a zero byte closes it
  // (that zero byte carries a random end flag, which makes no difference).
  task automatic send_message(input logic zero_end);
    for (int i = 0; i < msg.size(); i++) begin
      send_byte(msg[i], !zero_end && i == msg.size() - 1);
    end
    if (zero_end) send_byte(8'h00, 1'($urandom_range(0, 1)));
    msg_count++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_byte(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == avoid);
    return b;
  endfunction

  // random non-zero bytes, never the given delimiter
  task automatic put_filler(input int n, input logic [7:0] avoid);
    repeat (n) msg.push_back(pick_byte(avoid));
  endtask

  // Whitespace, sign, digits and trailing junk in random measure. Long digit
  // runs push the magnitude into saturation; no digits at all is a missing field.
  task automatic put_number();
    logic [7:0] c;
    int         r;
    int         n;
    repeat ($urandom_range(0, 2)) begin
      c = $urandom_range(0, 1) ? atmp_pkg::CH_SPACE
                               : 8'($urandom_range(atmp_pkg::CH_TAB, atmp_pkg::CH_CR));
      msg.push_back(c);
    end
    case ($urandom_range(0, 2))
      1: msg.push_back(atmp_pkg::CH_PLUS);
      2: msg.push_back(atmp_pkg::CH_MINUS);
      default: ;
    endcase
    r = $urandom_range(0, 9);
    n = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 5) : $urandom_range(9, 12);
    repeat (n) begin
      c = atmp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      msg.push_back(c);
    end
    if ($urandom_range(0, 3) == 0) msg.push_back(pick_byte(atmp_pkg::CH_COMMA));
  endtask

  // A time-sync reply in the expected layout with random content (a number may lack digits).
  task automatic build_reply();
    msg.delete();
    put_text("<OK");
    put_filler($urandom_range(0, 3), atmp_pkg::CH_HASH);
    put_text("#TIMESYNCA,");
    put_filler($urandom_range(1, 5), atmp_pkg::CH_SEMI);
    put_text(";");
    if ($urandom_range(0, 3) == 0) put_text(",,");
    put_number();
    put_text(",");
    if ($urandom_range(0, 3) == 0) put_text(",");
    put_number();
    put_text(",");
    put_filler($urandom_range(0, 11), atmp_pkg::CH_STAR);
    if ($urandom_range(0, 3) != 0) begin
      put_text("*");
      put_filler($urandom_range(0, 3), 8'h00);
    end
  endtask

  task automatic directed(input string s, input logic zero_end);
    msg.delete();
    put_text(s);
    send_message(zero_end || msg.size() == 0);
  endtask

  initial begin
    int r;
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each way a message can end, plus field extremes.
    directed("", 1'b1);                                  // empty: no reply
    directed("X", 1'b0);                                 // no opening bracket
    directed("<Q", 1'b0);                                // bad reply word
    directed("<OK", 1'b0);                               // ends before '#'
    directed("<OK#TIMES", 1'b0);                         // ends in token, prefix good
    directed("<OK#TIMEZ", 1'b1);                         // ends in token, prefix bad
    directed("<OK#TIMESYNCB,h;1,2,s*", 1'b0);            // wrong message type
    directed("<OK#TIMESYNCA,h;+,1,s*", 1'b0);            // week with no digits
    directed("<OK#TIMESYNCA,h;-5,2147483648,**", 1'b0);  // ends before status text
    directed("<OK x#TIMESYNCA,COM1;,,  -2147483648,99999999999,FINESTEERING*ab", 1'b0);
    directed("<OK#TIMESYNCA,h;\t +0012z,-0,A*", 1'b1);   // leading blanks, junk after digits
    directed("<OK#TIMESYNCA,h;2147483647,-99999999999,\377~", 1'b0);

    // Random: mostly well-formed replies, some cut short, corrupted or noise.
    while (bytes_sent < 1400 || msg_count < 45) begin
      // a long run with neither side idling
      gaps_on <= !(msg_count >= 15 && msg_count < 30);
      if (msg_count == 40) begin
        // hold off until every reply so far has been returned
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 85) begin
        build_reply();
        if (r >= 55 && r < 70) begin
          k = $urandom_range(1, msg.size());
          while (msg.size() > k) void'(msg.pop_back());
        end else if (r >= 70) begin
          msg[$urandom_range(0, msg.size() - 1)] = pick_byte(8'h00);
        end
      end else begin
        msg.delete();
        if ($urandom_range(0, 1)) put_text("<");
        put_filler($urandom_range(0, 8), 8'h00);
      end
      send_message($urandom_range(0, 4) == 0 || msg.size() == 0);
    end

    // Drain: one edge first so the outstanding count covers the last transfer.
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d messages (directed cases, intact, truncated,",
             bytes_sent, msg_count);
    $display("corrupted and noise replies); %0d parsed cleanly, rest error codes.",
             clean_replies);
    if (fail_count == 0 && awaited == 0) begin
      $display("ascii_time_message_parser test passed");
    end else begin
      $display("ascii_time_message_parser test failed");
    end
    $finish;
  end

endmodule
